// File: sv/fbpal_pkg.sv
// Shared types and constants for the packed 4bpp framebuffer with palette.
`default_nettype none

package fbpal_pkg;

    localparam int WIDTH_PIXELS = 640;
    localparam int HEIGHT_LINES = 480;
    localparam int NUM_COLOURS  = 16;

    localparam int LINE_BYTES  = WIDTH_PIXELS / 2;
    localparam int STORE_BYTES = WIDTH_PIXELS * HEIGHT_LINES / 2;
    localparam int ADDR_W      = $clog2(STORE_BYTES);
    localparam int IDX_W       = $clog2(LINE_BYTES * 512 + 512 + 4);
    localparam int CNT_W       = $clog2(LINE_BYTES + 1);
    localparam int GLYPH_BYTES = 4;
    localparam int PAL_W       = $clog2(NUM_COLOURS);

    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 32;

    typedef enum logic [2:0] {
        FUNC_PLOT  = 3'd0,
        FUNC_GLYPH = 3'd1,
        FUNC_PAL   = 3'd2,
        FUNC_CLEAR = 3'd3,
        FUNC_READ  = 3'd4
    } func_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADDR,
        ST_READ,
        ST_WRITE,
        ST_PAL,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic start;
        logic mem_wr;
        logic advance;
        logic pal_rd;
        logic pal_wr;
    } cmd_t;

    typedef struct packed {
        func_t func;
        logic  rmw;
        logic  last;
        logic  clr_skip;
    } status_t;

endpackage

`default_nettype wire

// File: sv/fbpal_ctrl.sv
// Controller state machine sequencing plot, glyph, palette, clear and read items.
`default_nettype none

module fbpal_ctrl
    import fbpal_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_tvalid,
    output logic         s_tready,
    output logic         m_tvalid,
    input  wire logic    m_tready,
    input  wire status_t status,
    output cmd_t         cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_ADDR;
                end
            end
            ST_ADDR: begin
                cmd.start = 1'b1;
                case (status.func)
                    FUNC_PLOT: state_next = ST_READ;
                    FUNC_GLYPH: state_next = status.rmw ? ST_READ : ST_WRITE;
                    FUNC_PAL: begin
                        cmd.pal_wr = 1'b1;
                        state_next = ST_IDLE;
                    end
                    FUNC_CLEAR: state_next = status.clr_skip ? ST_IDLE : ST_WRITE;
                    FUNC_READ: state_next = ST_READ;
                    default: state_next = ST_IDLE;
                endcase
            end
            ST_READ: begin
                state_next = (status.func == FUNC_READ) ? ST_PAL : ST_WRITE;
            end
            ST_WRITE: begin
                cmd.mem_wr  = 1'b1;
                cmd.advance = 1'b1;
                if (status.last) begin
                    state_next = ST_IDLE;
                end else if (status.rmw) begin
                    state_next = ST_READ;
                end else begin
                    state_next = ST_WRITE;
                end
            end
            ST_PAL: begin
                cmd.pal_rd = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

`default_nettype wire

// File: sv/fbpal_datapath.sv
// Datapath: item registers, byte address walker, frame store and palette memories.
`default_nettype none

module fbpal_datapath
    import fbpal_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    input  wire cmd_t                 cmd,
    output status_t                   status,
    output logic [M_TDATA_W-1:0]      m_tdata
);

    func_t        func_reg;
    logic [9:0]   x_reg;
    logic [8:0]   y_reg;
    logic [3:0]   colour_reg;
    logic [3:0]   bg_reg;
    logic         transp_reg;
    logic [7:0]   bits_reg;
    logic [PAL_W-1:0] pidx_reg;
    logic [15:0]  pval_reg;

    logic [IDX_W-1:0] addr_reg;
    logic [IDX_W-1:0] base_idx;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_load;
    logic             in_range;

    logic [7:0] frame_mem [STORE_BYTES];
    logic [7:0] rdata_reg;
    logic [7:0] wdata;
    logic [3:0] lo_nib;
    logic [3:0] hi_nib;

    logic [15:0] pal_mem [NUM_COLOURS];
    logic [NUM_COLOURS-1:0] pal_valid_reg;
    logic [15:0] pal_lo_reg;
    logic [15:0] pal_hi_reg;
    logic        pal_lo_ok_reg;
    logic        pal_hi_ok_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            func_reg   <= func_t'(s_tdata[2:0]);
            x_reg      <= s_tdata[12:3];
            y_reg      <= s_tdata[21:13];
            colour_reg <= s_tdata[25:22];
            bg_reg     <= s_tdata[29:26];
            transp_reg <= s_tdata[30];
            pidx_reg   <= s_tdata[42:39];
            pval_reg   <= s_tdata[58:43];
        end
    end

    always_comb begin
        base_idx = IDX_W'(LINE_BYTES) * IDX_W'(y_reg);
        if (func_reg != FUNC_CLEAR) begin
            base_idx = base_idx + IDX_W'(x_reg[9:1]);
        end
        case (func_reg)
            FUNC_GLYPH: cnt_load = CNT_W'(GLYPH_BYTES);
            FUNC_CLEAR: cnt_load = CNT_W'(LINE_BYTES);
            default:    cnt_load = CNT_W'(1);
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            bits_reg <= s_tdata[38:31];
        end else if (cmd.advance) begin
            bits_reg <= {bits_reg[5:0], 2'b00};
        end
        if (cmd.start) begin
            addr_reg <= base_idx;
            cnt_reg  <= cnt_load;
        end else if (cmd.advance) begin
            addr_reg <= addr_reg + IDX_W'(1);
            cnt_reg  <= cnt_reg - CNT_W'(1);
        end
    end

    assign in_range = (addr_reg < IDX_W'(STORE_BYTES));

    always_comb begin
        lo_nib = rdata_reg[3:0];
        hi_nib = rdata_reg[7:4];
        case (func_reg)
            FUNC_PLOT: begin
                if (x_reg[0]) begin
                    hi_nib = colour_reg;
                end else begin
                    lo_nib = colour_reg;
                end
            end
            FUNC_GLYPH: begin
                if (transp_reg) begin
                    if (bits_reg[7]) lo_nib = colour_reg;
                    if (bits_reg[6]) hi_nib = colour_reg;
                end else begin
                    lo_nib = bits_reg[7] ? colour_reg : bg_reg;
                    hi_nib = bits_reg[6] ? colour_reg : bg_reg;
                end
            end
            default: begin
                lo_nib = 4'h0;
                hi_nib = 4'h0;
            end
        endcase
        wdata = {hi_nib, lo_nib};
    end

    always_ff @(posedge aclk) begin
        if (cmd.mem_wr && in_range) begin
            frame_mem[addr_reg[ADDR_W-1:0]] <= wdata;
        end
        rdata_reg <= frame_mem[addr_reg[ADDR_W-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (cmd.pal_wr) begin
            pal_mem[pidx_reg] <= pval_reg;
        end
        if (cmd.pal_rd) begin
            pal_lo_reg <= pal_mem[rdata_reg[3:0]];
            pal_hi_reg <= pal_mem[rdata_reg[7:4]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pal_valid_reg <= '0;
            pal_lo_ok_reg <= 1'b0;
            pal_hi_ok_reg <= 1'b0;
        end else begin
            if (cmd.pal_wr) begin
                pal_valid_reg[pidx_reg] <= 1'b1;
            end
            if (cmd.pal_rd) begin
                pal_lo_ok_reg <= pal_valid_reg[rdata_reg[3:0]] && in_range;
                pal_hi_ok_reg <= pal_valid_reg[rdata_reg[7:4]] && in_range;
            end
        end
    end

    assign m_tdata = {pal_hi_ok_reg ? pal_hi_reg : 16'h0000,
                      pal_lo_ok_reg ? pal_lo_reg : 16'h0000};

    assign status.func     = func_reg;
    assign status.rmw      = (func_reg == FUNC_PLOT) || ((func_reg == FUNC_GLYPH) && transp_reg);
    assign status.last     = (cnt_reg == CNT_W'(1));
    assign status.clr_skip = ({1'b0, y_reg} >= 10'(HEIGHT_LINES));

endmodule

`default_nettype wire

// File: sv/packed_4bpp_framebuffer_palette.sv
// Top level of the packed 4bpp framebuffer with a 16-entry palette.
//
// Commands enter on the s_ stream, one item at a time; s_tready is high only
// while the block is idle. Read pair items return one result on the m_ stream;
// all other functions return nothing.
// Steps per item, from acceptance to the next acceptance:
//   palette write, unused code or clear of a line past the end: address only
//   plot: address, read, write of one byte
//   opaque glyph row: address, a write per byte; transparent: read-modify-write
//   line clear: address, then a write per byte of the line (320 at 640 pixels)
//   read pair: address, frame read, palette lookup, then the result is valid
// The frame store has one write and one registered read port, which sets the
// byte-per-cycle pace of clears and opaque glyph rows.
// Reset returns to idle and empties the palette to zero; the frame store keeps
// no reset and must be written before it is read.
// When the receiver stalls, the result holds on m_tdata and no new item is
// taken until it is accepted.
`default_nettype none

module packed_4bpp_framebuffer_palette
    import fbpal_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // func[2:0], x[12:3], y[21:13], colour[25:22], background[29:26],
    // transparent[30], glyph_bits[38:31], palette_index[42:39],
    // palette_value[58:43], zero fill[63:59]
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // pixel_pair[31:0]
    output logic [M_TDATA_W-1:0]      m_tdata
);

    cmd_t    cmd;
    status_t status;

    fbpal_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    fbpal_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tdata (s_tdata),
        .cmd     (cmd),
        .status  (status),
        .m_tdata (m_tdata)
    );

endmodule

`default_nettype wire

// File: dv/tb_packed_4bpp_framebuffer_palette.sv
// Self-checking testbench for the packed 4bpp framebuffer with palette: directed and random items.
`timescale 1ns / 100ps

module tb_packed_4bpp_framebuffer_palette;
    import fbpal_pkg::*;

    localparam logic [2:0] FUNC_SPARE_FIRST = 3'd5;
    localparam logic [2:0] FUNC_SPARE_LAST  = 3'd7;
    localparam int         CYCLE_LIMIT      = 400_000;
    localparam int         DRAIN_CYCLES     = 400;
    localparam int         MAX_REPORTS      = 10;

    typedef struct packed {
        logic [4:0]  pad;
        logic [15:0] palette_value;
        logic [3:0]  palette_index;
        logic [7:0]  glyph_bits;
        logic        transparent;
        logic [3:0]  background;
        logic [3:0]  colour;
        logic [8:0]  y;
        logic [9:0]  x;
        logic [2:0]  func;
    } fb_cmd_t;

    class fb_shadow;
        bit [7:0]    frame_mem [STORE_BYTES];
        bit          defined   [STORE_BYTES];
        logic [15:0] colour_lut [NUM_COLOURS];
        logic [31:0] pending_pairs [$];
        int          mismatches;

        function new();
            foreach (colour_lut[i]) colour_lut[i] = '0;
            mismatches = 0;
        endfunction

        function int unsigned byte_at(logic [9:0] x, logic [8:0] y);
            return LINE_BYTES * int'(y) + int'(x) / 2;
        endfunction

        function bit readable(logic [9:0] x, logic [8:0] y);
            int unsigned n;
            n = byte_at(x, y);
            return (n >= STORE_BYTES) || defined[n];
        endfunction

        function void apply_command(fb_cmd_t c);
            int unsigned n;
            logic        lo_fg;
            logic        hi_fg;
            n = byte_at(c.x, c.y);
            case (c.func)
                FUNC_PLOT: begin
                    if (n < STORE_BYTES) begin
                        if (c.x[0])
                            frame_mem[n][7:4] = c.colour;
                        else
                            frame_mem[n][3:0] = c.colour;
                    end
                end
                FUNC_GLYPH: begin
                    for (int i = 0; i < GLYPH_BYTES; i++) begin
                        lo_fg = c.glyph_bits[7 - 2 * i];
                        hi_fg = c.glyph_bits[6 - 2 * i];
                        if (n + i < STORE_BYTES) begin
                            if (c.transparent) begin
                                if (lo_fg) frame_mem[n + i][3:0] = c.colour;
                                if (hi_fg) frame_mem[n + i][7:4] = c.colour;
                            end else begin
                                frame_mem[n + i] = {hi_fg ? c.colour : c.background,
                                                    lo_fg ? c.colour : c.background};
                                defined[n + i] = 1'b1;
                            end
                        end
                    end
                end
                FUNC_PAL: colour_lut[c.palette_index] = c.palette_value;
                FUNC_CLEAR: begin
                    if (c.y < HEIGHT_LINES) begin
                        for (int k = 0; k < LINE_BYTES; k++) begin
                            frame_mem[LINE_BYTES * int'(c.y) + k] = 8'h00;
                            defined[LINE_BYTES * int'(c.y) + k]   = 1'b1;
                        end
                    end
                end
                FUNC_READ: begin
                    if (n < STORE_BYTES)
                        pending_pairs.push_back({colour_lut[frame_mem[n][7:4]],
                                                 colour_lut[frame_mem[n][3:0]]});
                    else
                        pending_pairs.push_back(32'h0);
                end
                default: ;
            endcase
        endfunction

        function void note_mismatch(string msg);
            if (mismatches < MAX_REPORTS) $display("MISMATCH: %s", msg);
            mismatches++;
        endfunction

        function void check_pair(logic [31:0] got);
            logic [31:0] want;
            if (pending_pairs.size() == 0) begin
                note_mismatch($sformatf("pixel_pair %h with none expected", got));
                return;
            end
            want = pending_pairs.pop_front();
            if (got !== want)
                note_mismatch($sformatf("pixel_pair expected %h actual %h", want, got));
        endfunction
    endclass

    logic          aclk     = 1'b0;
    logic          aresetn  = 1'b0;
    logic          s_tvalid = 1'b0;
    logic          s_tready;
    logic [63:0]   s_tdata  = '0;
    logic          m_tvalid;
    logic          m_tready = 1'b0;
    logic [31:0]   m_tdata;

    logic          hold_results  = 1'b0;
    int            send_idle_pct = 0;
    int            recv_idle_pct = 0;
    int            cycle_count   = 0;
    fb_shadow      board = new();

    packed_4bpp_framebuffer_palette i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_packed_4bpp_framebuffer_palette: errors");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) board.check_pair(m_tdata);
        m_tready <= !hold_results && ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic fb_cmd_t make_cmd(logic [2:0] func, int x, int y, int colour,
                                         int background, bit transparent, int glyph_bits,
                                         int palette_index, int palette_value);
        fb_cmd_t c;
        c               = '0;
        c.func          = func;
        c.x             = 10'(x);
        c.y             = 9'(y);
        c.colour        = 4'(colour);
        c.background    = 4'(background);
        c.transparent   = transparent;
        c.glyph_bits    = 8'(glyph_bits);
        c.palette_index = 4'(palette_index);
        c.palette_value = 16'(palette_value);
        return c;
    endfunction

    // lines 0..3 and the last two lines are cleared first and stay readable
    function automatic logic [8:0] work_line();
        int unsigned k;
        k = $urandom_range(5);
        return (k < 4) ? 9'(k) : 9'(HEIGHT_LINES - 6 + k);
    endfunction

    function automatic fb_cmd_t random_cmd();
        fb_cmd_t     c;
        int unsigned pick;
        c     = {$urandom, $urandom};
        c.pad = '0;
        pick  = $urandom_range(99);
        if (pick < 30)
            c.func = FUNC_PLOT;
        else if (pick < 55)
            c.func = FUNC_GLYPH;
        else if (pick < 65)
            c.func = FUNC_PAL;
        else if (pick < 67)
            c.func = FUNC_CLEAR;
        else if (pick < 97)
            c.func = FUNC_READ;
        else
            c.func = 3'($urandom_range(FUNC_SPARE_LAST, FUNC_SPARE_FIRST));
        if ($urandom_range(99) < 80) c.y = work_line();
        if (c.func == FUNC_CLEAR && $urandom_range(3) == 0)
            c.y = 9'($urandom_range(511, HEIGHT_LINES));
        if (c.func == FUNC_READ && !board.readable(c.x, c.y)) begin
            c.y = work_line();
            c.x = 10'($urandom_range(WIDTH_PIXELS - 1));
        end
        return c;
    endfunction

    task automatic send_cmd(input fb_cmd_t c);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        do @(posedge aclk); while (!s_tready);
        board.apply_command(c);
    endtask

    task automatic send_random(input int count);
        repeat (count) send_cmd(random_cmd());
    endtask

    task automatic send_directed();
        send_cmd(make_cmd(FUNC_READ, 1023, 511, 0, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(FUNC_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(FUNC_CLEAR, 0, 1, 0, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(FUNC_CLEAR, 0, 2, 0, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(FUNC_CLEAR, 0, 3, 0, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(FUNC_CLEAR, 0, HEIGHT_LINES - 2, 0, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(FUNC_CLEAR, 0, HEIGHT_LINES - 1, 0, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(FUNC_CLEAR, 1023, 511, 0, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(FUNC_PAL, 0, 0, 0, 0, 0, 0, 0, 16'hFFFF));
        send_cmd(make_cmd(FUNC_PAL, 0, 0, 0, 0, 0, 0, 15, 16'h8001));
        send_cmd(make_cmd(FUNC_PAL, 0, 0, 0, 0, 0, 0, 10, 16'h5A5A));
        send_cmd(make_cmd(FUNC_PLOT, 0, 0, 15, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(FUNC_PLOT, 1, 0, 10, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(FUNC_READ, 0, 0, 0, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(FUNC_PLOT, 1023, 511, 15, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(FUNC_PLOT, 1023, HEIGHT_LINES - 2, 10, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(FUNC_READ, 1023, HEIGHT_LINES - 2, 0, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(FUNC_GLYPH, 3, 1, 15, 10, 0, 8'hA5, 0, 0));
        send_cmd(make_cmd(FUNC_READ, 4, 1, 0, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(FUNC_GLYPH, 638, HEIGHT_LINES - 1, 10, 15, 1, 8'hFF, 0, 0));
        send_cmd(make_cmd(FUNC_READ, 639, HEIGHT_LINES - 1, 0, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(FUNC_SPARE_FIRST, 0, 0, 5, 5, 0, 8'hFF, 0, 0));
        send_cmd(make_cmd(FUNC_SPARE_FIRST + 3'd1, 0, 0, 5, 5, 0, 8'hFF, 0, 0));
        send_cmd(make_cmd(FUNC_SPARE_LAST, 0, 0, 5, 5, 0, 8'hFF, 0, 0));
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn       <= 1'b1;
        send_idle_pct <= 12;
        recv_idle_pct <= 71;
        @(posedge aclk);
        send_directed();
        fork
            send_random(430);
            begin
                repeat (150) @(posedge aclk);
                hold_results <= 1'b1;
                repeat (400) @(posedge aclk);
                hold_results <= 1'b0;
            end
        join
        send_idle_pct <= 71;
        recv_idle_pct <= 12;
        send_random(430);
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
        send_random(440);
        s_tvalid <= 1'b0;
        while (board.pending_pairs.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (board.mismatches == 0)
            $display("tb_packed_4bpp_framebuffer_palette: clean");
        else
            $display("tb_packed_4bpp_framebuffer_palette: errors");
        $finish;
    end

endmodule
